FILE: src/itcr_pkg.sv
// Shared constants, types and helpers for the integer to radix text unit.
package itcr_pkg;

  localparam int ALPHABET_SLOTS_DFLT = 64;
  localparam int VALUE_BITS_DFLT     = 32;

  localparam int CFG_REGS   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CHAR_W     = 8;
  localparam int SEEN_W     = 128;

  localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_D0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_D9      = 8'h39;
  localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2D;

  typedef struct packed {
    logic scan;
    logic look;
  } alpha_req_t;

  typedef struct packed {
    logic done;
    logic ok;
  } scan_stat_t;

  typedef struct packed {
    logic done;
    logic nz;
  } div_stat_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) ||
           (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_D0 && c <= CH_D9);
  endfunction

endpackage

FILE: src/itcr_num_if.sv
// Input channel: one signed number per beat.
interface itcr_num_if #(
  parameter int VALUE_BITS = itcr_pkg::VALUE_BITS_DFLT
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink (input valid, input number_in, output ready);
endinterface

FILE: src/itcr_char_if.sv
// Output channel: one character per beat, with an end-of-number flag.
interface itcr_char_if;
  logic                          valid;
  logic                          ready;
  logic [itcr_pkg::CHAR_W-1:0]   char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

FILE: src/itcr_alpha.sv
// Alphabet row store with byte-serial validation scan and digit-to-character lookup.
module itcr_alpha #(
  parameter int ALPHABET_SLOTS = itcr_pkg::ALPHABET_SLOTS_DFLT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [itcr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [itcr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  itcr_pkg::alpha_req_t                req_i,
  input  logic [$clog2(ALPHABET_SLOTS)-1:0]   digit_i,
  output itcr_pkg::scan_stat_t                stat_o,
  output logic [$clog2(ALPHABET_SLOTS+1)-1:0] len_o,
  output logic [itcr_pkg::CHAR_W-1:0]         char_o
);

  localparam int Rows = (ALPHABET_SLOTS + 7) / 8;
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int LenW = $clog2(ALPHABET_SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;

  logic [itcr_pkg::CFG_DATA_W-1:0] alpha_mem_q [Rows];
  logic [Rows-1:0]                 row_vld_q;
  logic [itcr_pkg::CFG_DATA_W-1:0] sh_q;
  logic [2:0]                      sel_q;
  logic [1:0]                      st_q, st_d;
  logic [LenW-1:0]                 k_q, k_d, k_inc;
  logic [2:0]                      bc_q, bc_d;
  logic [RowW-1:0]                 row_q, row_d;
  logic                            ok_q, ok_d;
  logic                            done_q, done_d;
  logic [itcr_pkg::SEEN_W-1:0]     seen_q;
  logic                            clr_seen, set_seen;
  logic                            cfg_hit;
  logic [RowW-1:0]                 cfg_row;
  logic [8:0]                      dig_ext;
  logic [RowW-1:0]                 look_row, rd_row;
  logic                            rd_en;
  logic [itcr_pkg::CHAR_W-1:0]     c;

  assign cfg_hit  = cfg_idx_i < itcr_pkg::CFG_IDX_W'(Rows);
  assign cfg_row  = RowW'(cfg_idx_i);
  assign dig_ext  = 9'(digit_i);
  assign look_row = RowW'(dig_ext[8:3]);
  assign rd_en    = (st_q == S_RD) || req_i.look;
  assign rd_row   = (st_q == S_RD) ? row_q : look_row;
  assign c        = sh_q[7:0];
  assign k_inc    = k_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cfg_we_i && cfg_hit) begin
      alpha_mem_q[cfg_row] <= cfg_data_i;
    end
  end

  // a row never written reads as zero, i.e. an empty alphabet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cfg_we_i && cfg_hit) begin
      row_vld_q[cfg_row] <= 1'b1;
    end
  end

  // read register doubles as the byte shift line during the scan
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      sh_q <= row_vld_q[rd_row] ? alpha_mem_q[rd_row] : '0;
    end else if (st_q == S_BYTE) begin
      sh_q <= {8'h00, sh_q[itcr_pkg::CFG_DATA_W-1:8]};
    end
    if (req_i.look) begin
      sel_q <= dig_ext[2:0];
    end
  end

  always_comb begin
    st_d     = st_q;
    k_d      = k_q;
    bc_d     = bc_q;
    row_d    = row_q;
    ok_d     = ok_q;
    done_d   = 1'b0;
    clr_seen = 1'b0;
    set_seen = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (req_i.scan) begin
          st_d     = S_RD;
          k_d      = '0;
          bc_d     = '0;
          row_d    = '0;
          ok_d     = 1'b1;
          clr_seen = 1'b1;
        end
      end
      S_RD: begin
        st_d = S_BYTE;
      end
      S_BYTE: begin
        if (c == '0) begin
          st_d   = S_IDLE;
          done_d = 1'b1;
        end else if (!itcr_pkg::is_alnum(c) || seen_q[c[6:0]]) begin
          ok_d   = 1'b0;
          st_d   = S_IDLE;
          done_d = 1'b1;
        end else begin
          set_seen = 1'b1;
          k_d      = k_inc;
          if (k_inc == LenW'(ALPHABET_SLOTS)) begin
            st_d   = S_IDLE;
            done_d = 1'b1;
          end else if (bc_q == 3'd7) begin
            bc_d  = '0;
            row_d = row_q + 1'b1;
            st_d  = S_RD;
          end else begin
            bc_d = bc_q + 1'b1;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    bc_q  <= bc_d;
    row_q <= row_d;
    ok_q  <= ok_d;
    if (clr_seen) begin
      seen_q <= '0;
    end else if (set_seen) begin
      seen_q[c[6:0]] <= 1'b1;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ok   = ok_q && (k_q >= LenW'(2));
  assign len_o       = k_q;
  assign char_o      = sh_q[{sel_q, 3'b000} +: 8];

endmodule

FILE: src/itcr_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module itcr_div #(
  parameter int VALUE_BITS     = itcr_pkg::VALUE_BITS_DFLT,
  parameter int ALPHABET_SLOTS = itcr_pkg::ALPHABET_SLOTS_DFLT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [VALUE_BITS-1:0]               dividend_i,
  input  logic [$clog2(ALPHABET_SLOTS+1)-1:0] divisor_i,
  output itcr_pkg::div_stat_t                 stat_o,
  output logic [VALUE_BITS-1:0]               quot_o,
  output logic [$clog2(ALPHABET_SLOTS)-1:0]   rem_o
);

  localparam int LenW = $clog2(ALPHABET_SLOTS + 1);
  localparam int DigW = $clog2(ALPHABET_SLOTS);
  localparam int CntW = $clog2(VALUE_BITS);

  logic                  busy_q, done_q;
  logic [CntW-1:0]       cnt_q;
  logic [VALUE_BITS-1:0] q_q;
  logic [LenW-1:0]       rem_q, rem_nxt;
  logic                  nz_q;
  logic [LenW:0]         trial, diff;
  logic                  ge;

  assign trial   = {rem_q, q_q[VALUE_BITS-1]};
  assign ge      = trial >= {1'b0, divisor_i};
  assign diff    = trial - {1'b0, divisor_i};
  assign rem_nxt = ge ? diff[LenW-1:0] : trial[LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(VALUE_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      nz_q  <= 1'b0;
    end else if (busy_q) begin
      q_q   <= {q_q[VALUE_BITS-2:0], ge};
      rem_q <= rem_nxt;
      nz_q  <= nz_q | ge;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.nz   = nz_q;
  assign quot_o      = q_q;
  assign rem_o       = DigW'(rem_q);

endmodule

FILE: src/itcr_seq.sv
// Item sequencer: digit stack, sign handling and the output register.
module itcr_seq #(
  parameter int VALUE_BITS     = itcr_pkg::VALUE_BITS_DFLT,
  parameter int ALPHABET_SLOTS = itcr_pkg::ALPHABET_SLOTS_DFLT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [VALUE_BITS-1:0]             number_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [itcr_pkg::CHAR_W-1:0]       char_code_o,
  output logic                              last_char_o,
  output itcr_pkg::alpha_req_t              alpha_req_o,
  output logic [$clog2(ALPHABET_SLOTS)-1:0] digit_o,
  input  itcr_pkg::scan_stat_t              scan_stat_i,
  input  logic [itcr_pkg::CHAR_W-1:0]       alpha_char_i,
  output logic                              div_start_o,
  output logic [VALUE_BITS-1:0]             dividend_o,
  input  itcr_pkg::div_stat_t               div_stat_i,
  input  logic [VALUE_BITS-1:0]             quot_i,
  input  logic [$clog2(ALPHABET_SLOTS)-1:0] rem_i
);

  localparam int DigW = $clog2(ALPHABET_SLOTS);
  localparam int StkW = $clog2(VALUE_BITS);
  localparam int NdW  = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_SIGN   = 3'd4;
  localparam logic [2:0] S_POP    = 3'd5;
  localparam logic [2:0] S_LOOK   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]                  st_q, st_d;
  logic                        neg_q;
  logic [VALUE_BITS-1:0]       mag_q;
  logic [NdW-1:0]              nd_q, nd_dec;
  logic [DigW-1:0]             stk_q [VALUE_BITS];
  logic [DigW-1:0]             stk_rd_q;
  logic                        out_vld_q;
  logic [itcr_pkg::CHAR_W-1:0] out_char_q;
  logic                        out_last_q;
  logic                        accept, out_free, push, pop, emit_sign, emit_dig;

  assign in_ready_o = (st_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign push       = (st_q == S_DIV) && div_stat_i.done;
  assign pop        = (st_q == S_POP) && (nd_q != '0);
  assign emit_sign  = (st_q == S_SIGN) && neg_q && out_free;
  assign emit_dig   = (st_q == S_EMIT) && out_free;
  assign nd_dec     = nd_q - 1'b1;

  assign alpha_req_o.scan = accept;
  assign alpha_req_o.look = (st_q == S_LOOK);
  assign digit_o          = stk_rd_q;
  assign div_start_o      = (st_q == S_DSTART);
  assign dividend_o       = mag_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (accept) st_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_stat_i.done) st_d = scan_stat_i.ok ? S_DSTART : S_IDLE;
      end
      S_DSTART: begin
        st_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat_i.done) st_d = div_stat_i.nz ? S_DSTART : S_SIGN;
      end
      S_SIGN: begin
        if (!neg_q || out_free) st_d = S_POP;
      end
      S_POP: begin
        st_d = (nd_q == '0) ? S_IDLE : S_LOOK;
      end
      S_LOOK: begin
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) st_d = S_POP;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      nd_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        nd_q <= '0;
      end else if (push) begin
        nd_q <= nd_q + 1'b1;
      end else if (pop) begin
        nd_q <= nd_dec;
      end
      if (emit_sign || emit_dig) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= number_i[VALUE_BITS-1];
      mag_q <= number_i[VALUE_BITS-1] ? (~number_i + VALUE_BITS'(1)) : number_i;
    end else if (push) begin
      mag_q <= quot_i;
    end
    // digits come out least significant first, so they go out through a stack
    if (push) begin
      stk_q[nd_q[StkW-1:0]] <= rem_i;
    end
    if (pop) begin
      stk_rd_q <= stk_q[nd_dec[StkW-1:0]];
    end
    if (emit_sign) begin
      out_char_q <= itcr_pkg::MINUS_CODE;
      out_last_q <= 1'b0;
    end else if (emit_dig) begin
      out_char_q <= alpha_char_i;
      out_last_q <= (nd_q == '0);
    end
  end

  assign out_valid_o = out_vld_q;
  assign char_code_o = out_char_q;
  assign last_char_o = out_last_q;

endmodule

FILE: src/integer_to_custom_radix_text_unit.sv
// Top level of the integer to custom radix text unit.
// Converts each signed number on num_i into text on char_o, one character per beat: a minus
// sign for negative values, then the digits most significant first with last_char set on the
// final one. The radix and digit characters come from the alphabet written through the cfg
// port (register i holds bytes 8i..8i+7, byte 8i in bits 7:0, a zero byte ends it); an
// alphabet shorter than two characters, with a character that is not a letter or a decimal
// digit, or with a repeated character produces no output at all. One number is handled at a
// time. Per number, the alphabet is first validated by reading it row by row, eight characters
// per row, and checking each byte (a short alphabet validates sooner); then each digit takes
// one division in the bit-serial divider, then each digit is looked up and emitted, with a
// sign step before the digits and a final step to finish. The divider loop dominates, so
// larger radices, with fewer digits, take far less time. The last character may still wait
// at the output while the next number is taken in.
module integer_to_custom_radix_text_unit #(
  parameter int ALPHABET_SLOTS = itcr_pkg::ALPHABET_SLOTS_DFLT,
  parameter int VALUE_BITS     = itcr_pkg::VALUE_BITS_DFLT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [itcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [itcr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  itcr_num_if.sink                        num_i,
  itcr_char_if.source                     char_o
);

  localparam int LenW = $clog2(ALPHABET_SLOTS + 1);
  localparam int DigW = $clog2(ALPHABET_SLOTS);

  itcr_pkg::alpha_req_t        alpha_req;
  itcr_pkg::scan_stat_t        scan_stat;
  itcr_pkg::div_stat_t         div_stat;
  logic [DigW-1:0]             digit, rem;
  logic [LenW-1:0]             alpha_len;
  logic [itcr_pkg::CHAR_W-1:0] alpha_char;
  logic                        div_start;
  logic [VALUE_BITS-1:0]       dividend, quot, number;
  logic                        in_ready, out_valid, last_char;
  logic [itcr_pkg::CHAR_W-1:0] char_code;

  assign number         = $unsigned(num_i.number_in);
  assign num_i.ready    = in_ready;
  assign char_o.valid     = out_valid;
  assign char_o.char_code = char_code;
  assign char_o.last_char = last_char;

  itcr_alpha #(
    .ALPHABET_SLOTS (ALPHABET_SLOTS)
  ) u_alpha (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (alpha_req),
    .digit_i    (digit),
    .stat_o     (scan_stat),
    .len_o      (alpha_len),
    .char_o     (alpha_char)
  );

  itcr_div #(
    .VALUE_BITS     (VALUE_BITS),
    .ALPHABET_SLOTS (ALPHABET_SLOTS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (alpha_len),
    .stat_o     (div_stat),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  itcr_seq #(
    .VALUE_BITS     (VALUE_BITS),
    .ALPHABET_SLOTS (ALPHABET_SLOTS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (num_i.valid),
    .in_ready_o   (in_ready),
    .number_i     (number),
    .out_valid_o  (out_valid),
    .out_ready_i  (char_o.ready),
    .char_code_o  (char_code),
    .last_char_o  (last_char),
    .alpha_req_o  (alpha_req),
    .digit_o      (digit),
    .scan_stat_i  (scan_stat),
    .alpha_char_i (alpha_char),
    .div_start_o  (div_start),
    .dividend_o   (dividend),
    .div_stat_i   (div_stat),
    .quot_i       (quot),
    .rem_i        (rem)
  );

endmodule

FILE: src/itcr_port_chk.sv
// Port-level checks for the integer to custom radix text unit, bound to the top level.
module itcr_port_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [itcr_pkg::CHAR_W-1:0] char_code_i,
  input logic                        last_char_i
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_code_i) && $stable(last_char_i))
    else $error("output beat changed while stalled");

  // a digit always follows the sign
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (char_code_i == itcr_pkg::MINUS_CODE) |-> !last_char_i)
    else $error("minus sign flagged as last character");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> itcr_pkg::is_alnum(char_code_i) || (char_code_i == itcr_pkg::MINUS_CODE))
    else $error("character outside the alphabet set");

  // one number at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a number is in progress");

endmodule

bind integer_to_custom_radix_text_unit itcr_port_chk u_port_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (num_i.valid),
  .in_ready_i  (num_i.ready),
  .out_valid_i (char_o.valid),
  .out_ready_i (char_o.ready),
  .char_code_i (char_o.char_code),
  .last_char_i (char_o.last_char)
);

FILE: bench/radix_text_monitor.sv
// Watches the number and character channels, predicts the text of each number and checks it.
module radix_text_monitor
  import itcr_pkg::*;
#(
  parameter int ALPHABET_SLOTS = ALPHABET_SLOTS_DFLT,
  parameter int VALUE_BITS     = VALUE_BITS_DFLT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  num_valid_i,
  input  logic                  num_ready_i,
  input  logic [VALUE_BITS-1:0] number_i,
  input  logic                  char_valid_i,
  input  logic                  char_ready_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic                  last_char_i,
  output int                    chars_pending_o,
  output int                    mismatch_count_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_beat_t;

  logic [CFG_DATA_W-1:0] digit_regs [CFG_REGS];
  text_beat_t            pending_chars [$];
  text_beat_t            head_char;
  int                    mismatches;

  assign mismatch_count_o = mismatches;

  function automatic logic [CHAR_W-1:0] digit_char(input int k);
    return digit_regs[k / 8][(k % 8) * CHAR_W +: CHAR_W];
  endfunction

  function automatic bit char_allowed(input logic [CHAR_W-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_D0 && c <= CH_D9);
  endfunction

  // Radix of the current digit set, 0 when the set cannot be used.
  function automatic int digit_set_radix();
    int len;
    len = 0;
    while (len < ALPHABET_SLOTS && digit_char(len) != '0) len++;
    if (len < 2) return 0;
    for (int i = 0; i < len; i++) begin
      if (!char_allowed(digit_char(i))) return 0;
      for (int j = i + 1; j < len; j++) begin
        if (digit_char(j) == digit_char(i)) return 0;
      end
    end
    return len;
  endfunction

  task automatic predict_text(input logic [VALUE_BITS-1:0] value);
    logic [CHAR_W-1:0]     digits [64];
    logic [VALUE_BITS-1:0] abs_val;
    logic [63:0]           mag;
    logic [63:0]           radix;
    int                    len;
    int                    n_dig;
    bit                    neg;
    len = digit_set_radix();
    if (len == 0) return;
    neg = value[VALUE_BITS-1];
    // magnitude taken unsigned, so the most negative value comes out right
    abs_val = neg ? -value : value;
    mag = abs_val;
    radix = len;
    n_dig = 0;
    do begin
      digits[n_dig] = digit_char(int'(mag % radix));
      mag = mag / radix;
      n_dig++;
    end while (mag != 0);
    if (neg) pending_chars.push_back('{code: MINUS_CODE, last: 1'b0});
    for (int i = n_dig - 1; i >= 0; i--) begin
      pending_chars.push_back('{code: digits[i], last: (i == 0)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (digit_regs[r]) digit_regs[r] = '0;
      pending_chars.delete();
      mismatches = 0;
      chars_pending_o <= 0;
    end else begin
      // retire the output beat first: it belongs to an earlier number
      if (char_valid_i && char_ready_i) begin
        if (pending_chars.size() == 0) begin
          $error("char_code: expected none, got %02h (last_char %b)", char_code_i, last_char_i);
          mismatches++;
        end else begin
          head_char = pending_chars.pop_front();
          if (char_code_i !== head_char.code) begin
            $error("char_code: expected %02h, got %02h", head_char.code, char_code_i);
            mismatches++;
          end
          if (last_char_i !== head_char.last) begin
            $error("last_char: expected %b, got %b", head_char.last, last_char_i);
            mismatches++;
          end
        end
      end
      if (num_valid_i && num_ready_i) predict_text(number_i);
      if (cfg_we_i && cfg_idx_i < CFG_REGS) digit_regs[cfg_idx_i] = cfg_data_i;
      chars_pending_o <= pending_chars.size();
    end
  end

endmodule

FILE: bench/tb_integer_to_custom_radix_text_unit.sv
// Stimulus, digit set programming and verdict for the integer to custom radix text unit.
module tb_integer_to_custom_radix_text_unit;
  import itcr_pkg::*;

  localparam int ALPHABET_SLOTS = ALPHABET_SLOTS_DFLT;
  localparam int VALUE_BITS     = VALUE_BITS_DFLT;
  localparam int SET_BYTES      = CFG_REGS * 8;
  localparam int RUN_LIMIT      = 1_000_000;
  localparam int SETTLE_CYCLES  = 1400;
  localparam int LONG_HOLD      = 3000;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 6;
  localparam int HOLD_PHASE     = 5;
  localparam int PAUSE_PHASE    = 9;

  localparam logic [CFG_IDX_W-1:0]  SPARE_IDX_LO = CFG_IDX_W'(CFG_REGS);
  localparam logic [CFG_IDX_W-1:0]  SPARE_IDX_HI = '1;
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam string DIGIT_POOL =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  typedef enum int {
    SET_CLEAN,
    SET_REPEAT,
    SET_FOREIGN,
    SET_SHORT,
    SET_NO_END
  } set_flaw_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int src_idle_pct;
  int snk_stall_pct;
  int hold_left;
  int cycle_cnt;
  int chars_pending;
  int mismatch_count;

  logic [CHAR_W-1:0] set_bytes [SET_BYTES];
  // bytes just outside the letter and digit ranges, plus the high ones
  logic [CHAR_W-1:0] foreign_bytes [8] = '{8'h2F, 8'h3A, 8'h40, 8'h5B,
                                           8'h60, 8'h7B, 8'h80, 8'hFF};

  itcr_num_if #(.VALUE_BITS(VALUE_BITS)) num_ch ();
  itcr_char_if                           char_ch ();

  integer_to_custom_radix_text_unit #(
    .ALPHABET_SLOTS(ALPHABET_SLOTS),
    .VALUE_BITS    (VALUE_BITS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .num_i     (num_ch),
    .char_o    (char_ch)
  );

  radix_text_monitor #(
    .ALPHABET_SLOTS(ALPHABET_SLOTS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_text_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .num_valid_i     (num_ch.valid),
    .num_ready_i     (num_ch.ready),
    .number_i        (num_ch.number_in),
    .char_valid_i    (char_ch.valid),
    .char_ready_i    (char_ch.ready),
    .char_code_i     (char_ch.char_code),
    .last_char_i     (char_ch.last_char),
    .chars_pending_o (chars_pending),
    .mismatch_count_o(mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycle_cnt = 0;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("integer_to_custom_radix_text_unit verification failed");
    $finish;
  end

  // Character sink: random stalls, or a long hold-off when one is requested.
  initial begin
    char_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        char_ch.ready <= 1'b0;
      end else begin
        char_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic set_pace(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  task automatic send_number(input logic [VALUE_BITS-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      num_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    num_ch.valid     <= 1'b1;
    num_ch.number_in <= value;
    @(posedge clk_i);
    while (!num_ch.ready) @(posedge clk_i);
  endtask

  // Stop sending and wait for the text to drain; settle also covers a number that
  // an unusable digit set swallows while the block is still scanning it.
  task automatic drain_text(input bit settle);
    num_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic close_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_set();
    logic [CFG_DATA_W-1:0] word;
    for (int r = 0; r < CFG_REGS; r++) begin
      for (int b = 0; b < 8; b++) word[b*CHAR_W +: CHAR_W] = set_bytes[r*8 + b];
      write_reg(CFG_IDX_W'(r), word);
    end
    close_writes();
  endtask

  task automatic text_set(input string s);
    foreach (set_bytes[k]) set_bytes[k] = '0;
    for (int k = 0; k < s.len(); k++) set_bytes[k] = s[k];
    write_set();
  endtask

  task automatic random_set(input set_flaw_e flaw, input bit garbage);
    logic [CHAR_W-1:0] pool [62];
    logic [CHAR_W-1:0] tmp;
    int                len;
    int                j;
    int                pos;
    for (int i = 0; i < 62; i++) pool[i] = DIGIT_POOL[i];
    for (int i = 61; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    len = $urandom_range(1) ? $urandom_range(12, 2) : $urandom_range(62, 13);
    for (int k = 0; k < SET_BYTES; k++) begin
      if (k < len) set_bytes[k] = pool[k];
      else if (garbage && k > len) set_bytes[k] = CHAR_W'($urandom_range(255));
      else set_bytes[k] = '0;
    end
    case (flaw)
      SET_REPEAT: begin
        pos = $urandom_range(len - 1, 1);
        set_bytes[pos] = set_bytes[$urandom_range(pos - 1, 0)];
      end
      SET_FOREIGN: begin
        pos = $urandom_range(len - 1, 0);
        if ($urandom_range(1)) set_bytes[pos] = foreign_bytes[$urandom_range(7, 0)];
        else set_bytes[pos] = CHAR_W'($urandom_range(255, 1));
      end
      SET_SHORT: set_bytes[1] = '0;
      SET_NO_END: begin
        for (int k = 0; k < SET_BYTES; k++) begin
          set_bytes[k] = $urandom_range(3) ? pool[k % 62] : CHAR_W'($urandom_range(255, 1));
        end
      end
      default: ;
    endcase
    write_set();
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_number();
    case ($urandom_range(4))
      0: return VALUE_BITS'($urandom);
      1: return VALUE_BITS'($urandom_range(99));
      2: return -VALUE_BITS'($urandom_range(100, 1));
      3: return VAL_MAX - VALUE_BITS'($urandom_range(3));
      default: return VAL_MIN + VALUE_BITS'($urandom_range(3));
    endcase
  endfunction

  initial begin
    set_flaw_e flaw;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    num_ch.valid     = 1'b0;
    num_ch.number_in = '0;
    hold_left        = 0;
    set_pace(0, 0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty digit set after reset: numbers vanish
    send_number('0);
    send_number(VAL_MIN);
    drain_text(1'b1);

    text_set("01");
    send_number('0);
    send_number(1);
    send_number('1);
    send_number(VAL_MAX);
    send_number(VAL_MIN);
    drain_text(1'b1);

    text_set("0123456789");
    send_number(9);
    send_number(10);
    send_number(-10);
    send_number(1000000000);
    send_number(VAL_MAX);
    send_number(VAL_MIN);
    drain_text(1'b1);
    // writes past the last register must leave the set alone
    write_reg(SPARE_IDX_LO, {$urandom, $urandom});
    write_reg(SPARE_IDX_HI, {$urandom, $urandom});
    close_writes();
    send_number(12345);
    drain_text(1'b1);

    // every range boundary character, all valid
    text_set("azAZ09");
    send_number(5);
    send_number(-6);
    send_number(35);
    send_number(VAL_MIN);
    drain_text(1'b1);

    text_set(DIGIT_POOL);
    send_number(61);
    send_number(-62);
    send_number(VAL_MAX);
    send_number(VAL_MIN);
    drain_text(1'b1);

    text_set("Z");
    send_number(7);
    drain_text(1'b1);

    text_set("abca");
    send_number(-5);
    drain_text(1'b1);

    text_set("09@");
    send_number(3);
    drain_text(1'b1);

    // no terminating zero byte anywhere
    random_set(SET_NO_END, 1'b0);
    send_number(3);
    drain_text(1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: set_pace(0, 0);
        1: set_pace(72, 0);
        2: set_pace(0, 72);
        default: set_pace(33, 33);
      endcase
      if (p == HOLD_PHASE || p == PAUSE_PHASE || $urandom_range(99) >= 25) flaw = SET_CLEAN;
      else flaw = set_flaw_e'($urandom_range(4, 1));
      random_set(flaw, 1'(($urandom_range(1))));
      if (p == HOLD_PHASE) begin
        // sink holds off while numbers keep coming, so the block backs up
        src_idle_pct = 0;
        hold_left = LONG_HOLD;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_number(rand_number());
        if (p == PAUSE_PHASE && i == 2) drain_text(1'b0);
      end
      drain_text(1'b1);
    end

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("integer_to_custom_radix_text_unit verification clean");
    end else begin
      $display("integer_to_custom_radix_text_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/itcr_pkg.sv
src/itcr_num_if.sv
src/itcr_char_if.sv
src/itcr_alpha.sv
src/itcr_div.sv
src/itcr_seq.sv
src/integer_to_custom_radix_text_unit.sv
src/itcr_port_chk.sv
bench/radix_text_monitor.sv
bench/tb_integer_to_custom_radix_text_unit.sv
